// ===== sv/assert_macros.svh =====
// Assertion macros used by the RTL of the point operation block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that cons holds in the same cycle whenever ante holds.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Checks that cons holds in the cycle after ante holds.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== sv/gfld_pkg.sv =====
// Types and constants of the Lopez-Dahab point operation pipeline.
package gfld_pkg;

	localparam int M = 63;
	localparam int NV = 32;
	localparam int NL = 8;
	localparam int STEPS = 8;
	localparam int LVL_STAGES = (M + STEPS) / STEPS;
	localparam int NUM_LVLS = 5;
	localparam int NST = LVL_STAGES * NUM_LVLS;

	localparam logic [1:0] CFG_TAIL = 2'd0;
	localparam logic [1:0] CFG_A = 2'd1;
	localparam logic [1:0] CFG_B = 2'd2;

	localparam logic [M-1:0] TAIL_RST = M'(3);
	localparam logic [M-1:0] A_RST = M'(1);
	localparam logic [M-1:0] B_RST = M'(1);

	typedef logic [M-1:0] elem_t;

	typedef enum logic [1:0] {
		OP_DBL = 2'd0,
		OP_MIX = 2'd1,
		OP_ADD = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef struct packed {
		elem_t a;
		elem_t r;
		logic [M:0] b;
	} lane_t;

	typedef struct packed {
		op_t op;
		elem_t [NV-1:0] v;
		lane_t [NL-1:0] ln;
	} item_t;

endpackage

// ===== sv/gf2m_lopez_dahab_point_ops.sv =====
// Lopez-Dahab point double, mixed add and projective add over GF(2^63), fully pipelined.
// The block accepts one item per clock while the output is not stalled. The datapath
// is five levels of GF(2^m) multipliers, each level a shift-and-add multiplier that
// handles eight bits of the second operand per stage, eight stages per level, followed
// by one output register.
// A stall on the output freezes the whole pipeline. Configuration writes take effect
// immediately and must only be issued while the pipeline is empty.
`include "assert_macros.svh"

module gf2m_lopez_dahab_point_ops (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           opcode,
	input  gfld_pkg::elem_t      first_x,
	input  gfld_pkg::elem_t      first_y,
	input  gfld_pkg::elem_t      first_z,
	input  gfld_pkg::elem_t      second_x,
	input  gfld_pkg::elem_t      second_y,
	input  gfld_pkg::elem_t      second_z,
	output logic                 out_valid,
	input  logic                 out_stall,
	output gfld_pkg::elem_t      result_x,
	output gfld_pkg::elem_t      result_y,
	output gfld_pkg::elem_t      result_z,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  gfld_pkg::elem_t      cfg_data
);

	gfld_pkg::elem_t tail_q, ca_q, cb_q;
	gfld_pkg::item_t stg_s [gfld_pkg::NST];
	gfld_pkg::item_t nxt [gfld_pkg::NST];
	gfld_pkg::item_t in_item, last_item;
	logic [gfld_pkg::NST-1:0] vld_q;
	logic adv;

	// Runs eight multiply steps of one lane, most significant multiplier bit first.
	function automatic gfld_pkg::lane_t mul_steps(gfld_pkg::lane_t l, gfld_pkg::elem_t tail);
		gfld_pkg::lane_t o;
		logic top;
		o = l;
		for (int i = 0; i < gfld_pkg::STEPS; i++) begin
			top = o.r[gfld_pkg::M-1];
			o.r = {o.r[gfld_pkg::M-2:0], 1'b0} ^ (top ? tail : '0);
			if (o.b[gfld_pkg::M])
				o.r = o.r ^ o.a;
			o.b = {o.b[gfld_pkg::M-1:0], 1'b0};
		end
		return o;
	endfunction

	// Loads the lanes with the operands of one multiplier level.
	function automatic gfld_pkg::item_t setup(int lvl, gfld_pkg::item_t it,
			gfld_pkg::elem_t ca, gfld_pkg::elem_t cb);
		gfld_pkg::item_t o;
		gfld_pkg::elem_t [gfld_pkg::NL-1:0] x, y;
		gfld_pkg::elem_t dx, dy, dz;
		logic add;
		o = it;
		x = '0;
		y = '0;
		add = (it.op == gfld_pkg::OP_ADD);
		dx = (it.op == gfld_pkg::OP_MIX) ? it.v[3] : it.v[0];
		dy = (it.op == gfld_pkg::OP_MIX) ? it.v[4] : it.v[1];
		dz = (it.op == gfld_pkg::OP_MIX) ? gfld_pkg::elem_t'(1) : it.v[2];
		unique case (lvl)
			0: begin
				x[0] = dx; y[0] = dx;
				x[1] = dy; y[1] = dy;
				x[2] = dz; y[2] = dz;
				if (add) begin
					x[3] = it.v[0]; y[3] = it.v[5];
					x[4] = it.v[3]; y[4] = it.v[2];
					x[5] = it.v[5]; y[5] = it.v[5];
					x[6] = it.v[2]; y[6] = it.v[2];
					x[7] = it.v[2]; y[7] = it.v[5];
				end else begin
					x[3] = it.v[2]; y[3] = it.v[2];
					x[4] = it.v[3]; y[4] = it.v[2];
				end
			end
			1: begin
				x[0] = it.v[6]; y[0] = it.v[6];
				x[1] = it.v[8]; y[1] = it.v[8];
				x[2] = it.v[6]; y[2] = it.v[8];
				if (add) begin
					x[3] = it.v[9]; y[3] = it.v[9];
					x[4] = it.v[10]; y[4] = it.v[10];
					x[5] = it.v[1]; y[5] = it.v[11];
					x[6] = it.v[4]; y[6] = it.v[12];
				end else begin
					x[3] = ca; y[3] = it.v[12];
					x[4] = it.v[4]; y[4] = it.v[12];
					x[5] = it.v[2]; y[5] = it.v[14];
					x[6] = it.v[14]; y[6] = it.v[14];
				end
			end
			2: begin
				x[0] = cb; y[0] = it.v[16];
				x[1] = ca; y[1] = it.v[17];
				if (add) begin
					x[3] = it.v[9] ^ it.v[10]; y[3] = it.v[20] ^ it.v[21];
					x[4] = it.v[13]; y[4] = it.v[18] ^ it.v[19];
					x[5] = it.v[9]; y[5] = it.v[21] ^ it.v[19];
					x[6] = it.v[10]; y[6] = it.v[20] ^ it.v[18];
				end else begin
					x[3] = it.v[21]; y[3] = it.v[20] ^ it.v[18];
					x[4] = it.v[20]; y[4] = it.v[20];
					x[5] = it.v[19]; y[5] = it.v[20];
					x[6] = it.v[19]; y[6] = it.v[19];
				end
			end
			3: begin
				x[0] = it.v[22]; y[0] = it.v[17];
				x[1] = it.v[23]; y[1] = it.v[24];
				if (add) begin
					x[3] = it.v[9]; y[3] = it.v[25];
					x[4] = it.v[20]; y[4] = it.v[28];
					x[5] = it.v[25] ^ it.v[26]; y[5] = it.v[27];
				end else begin
					x[3] = it.v[3]; y[3] = it.v[26];
					x[4] = it.v[26]; y[4] = it.v[26];
				end
			end
			default: begin
				if (add) begin
					x[3] = it.v[30]; y[3] = it.v[28];
				end else begin
					x[3] = it.v[3] ^ it.v[4]; y[3] = it.v[31];
					x[4] = it.v[25] ^ it.v[26]; y[4] = it.v[30];
				end
			end
		endcase
		for (int i = 0; i < gfld_pkg::NL; i++) begin
			o.ln[i].a = x[i];
			o.ln[i].r = '0;
			o.ln[i].b = {1'b0, y[i]};
		end
		return o;
	endfunction

	// Stores the products of one multiplier level into the working variables.
	function automatic gfld_pkg::item_t finish(int lvl, gfld_pkg::item_t it);
		gfld_pkg::item_t o;
		gfld_pkg::elem_t [gfld_pkg::NL-1:0] p;
		logic add;
		o = it;
		add = (it.op == gfld_pkg::OP_ADD);
		for (int i = 0; i < gfld_pkg::NL; i++)
			p[i] = it.ln[i].r;
		unique case (lvl)
			1: begin
				o.v[6] = p[0];
				o.v[7] = p[1];
				o.v[8] = p[2];
				if (add) begin
					o.v[9] = p[3];
					o.v[10] = p[4];
					o.v[11] = p[5];
					o.v[12] = p[6];
					o.v[13] = p[7];
				end else begin
					o.v[12] = p[3];
					o.v[14] = p[4] ^ it.v[0];
				end
			end
			2: begin
				o.v[15] = p[0];
				o.v[16] = p[1];
				o.v[17] = p[2];
				if (add) begin
					o.v[18] = p[3];
					o.v[19] = p[4];
					o.v[20] = p[5];
					o.v[21] = p[6];
				end else begin
					o.v[18] = p[3];
					o.v[19] = p[4] ^ it.v[1];
					o.v[20] = p[5];
					o.v[21] = p[6];
				end
			end
			3: begin
				o.v[22] = p[0];
				o.v[23] = it.v[15] ^ p[0];
				o.v[24] = p[1] ^ it.v[7] ^ p[0];
				if (add) begin
					o.v[25] = p[3];
					o.v[26] = p[4];
					o.v[27] = p[5] ^ p[6];
					o.v[28] = it.v[18] ^ it.v[19];
				end else begin
					o.v[25] = p[5];
					o.v[26] = p[4];
					o.v[27] = p[6] ^ p[3] ^ p[5];
				end
			end
			4: begin
				o.v[29] = p[0] ^ p[1];
				if (add) begin
					o.v[30] = p[3] ^ p[4];
					o.v[31] = p[5];
				end else begin
					o.v[30] = p[3] ^ it.v[27];
					o.v[31] = p[4];
				end
			end
			default: begin
				o = it;
			end
		endcase
		return o;
	endfunction

	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;
	assign cfg_ready = 1'b1;

	always_comb begin
		in_item = '0;
		in_item.op = gfld_pkg::op_t'(opcode);
		in_item.v[0] = first_x;
		in_item.v[1] = first_y;
		in_item.v[2] = first_z;
		in_item.v[3] = second_x;
		in_item.v[4] = second_y;
		in_item.v[5] = second_z;
	end

	for (genvar s = 0; s < gfld_pkg::NST; s++) begin : g_stage
		localparam int LVL = s / gfld_pkg::LVL_STAGES;
		localparam bit FIRST = (s % gfld_pkg::LVL_STAGES) == 0;
		gfld_pkg::item_t pre;
		if (s == 0) begin : g_in
			assign pre = setup(0, in_item, ca_q, cb_q);
		end else if (FIRST) begin : g_lvl
			assign pre = setup(LVL, finish(LVL, stg_s[s-1]), ca_q, cb_q);
		end else begin : g_mid
			assign pre = stg_s[s-1];
		end
		always_comb begin
			nxt[s] = pre;
			for (int i = 0; i < gfld_pkg::NL; i++)
				nxt[s].ln[i] = mul_steps(pre.ln[i], tail_q);
		end
		always_ff @(posedge clk) begin
			if (adv)
				stg_s[s] <= nxt[s];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_valid <= 1'b0;
		end else if (adv) begin
			vld_q <= {vld_q[gfld_pkg::NST-2:0], in_valid};
			out_valid <= vld_q[gfld_pkg::NST-1];
		end
	end

	assign last_item = finish(gfld_pkg::NUM_LVLS, stg_s[gfld_pkg::NST-1]);

	always_ff @(posedge clk) begin
		if (adv) begin
			unique case (last_item.op)
				gfld_pkg::OP_DBL: begin
					result_x <= last_item.v[23];
					result_y <= last_item.v[29];
					result_z <= last_item.v[17];
				end
				gfld_pkg::OP_MIX: begin
					if (last_item.v[14] == '0) begin
						result_x <= last_item.v[23];
						result_y <= last_item.v[29];
						result_z <= last_item.v[17];
					end else begin
						result_x <= last_item.v[27];
						result_y <= last_item.ln[3].r ^ last_item.ln[4].r;
						result_z <= last_item.v[26];
					end
				end
				gfld_pkg::OP_ADD: begin
					result_x <= last_item.v[27];
					result_y <= last_item.ln[3].r ^ last_item.v[31];
					result_z <= last_item.v[26];
				end
				default: begin
					result_x <= '0;
					result_y <= '0;
					result_z <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_q <= gfld_pkg::TAIL_RST;
			ca_q <= gfld_pkg::A_RST;
			cb_q <= gfld_pkg::B_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				gfld_pkg::CFG_TAIL: tail_q <= cfg_data;
				gfld_pkg::CFG_A: ca_q <= cfg_data;
				gfld_pkg::CFG_B: cb_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	`ASSERT_NEXT(a_accept_enters, clk, arst_n, in_valid && !in_stall, vld_q[0])
	`ASSERT_NEXT(a_stall_freezes, clk, arst_n, !adv, $stable(vld_q) && out_valid)
	`ASSERT_NEXT(a_last_to_out, clk, arst_n, vld_q[gfld_pkg::NST-1] && adv, out_valid)

endmodule

// ===== tb/gf2m_lopez_dahab_point_ops_test.sv =====
// Self-checking test of the Lopez-Dahab point operation pipeline against a behavioral predictor.
module gf2m_lopez_dahab_point_ops_test;
	timeunit 1ns;
	timeprecision 1ps;

	typedef gfld_pkg::elem_t elem_t;
	typedef gfld_pkg::op_t op_t;

	typedef struct {
		elem_t x;
		elem_t y;
		elem_t z;
	} point_t;

	class point_scoreboard;
		point_t pending[$];
		int mismatches;
		int checked;
		elem_t tail;
		elem_t ca;
		elem_t cb;

		function elem_t times_t(elem_t r);
			elem_t s;
			s = r << 1;
			if (r[gfld_pkg::M-1])
				s ^= tail;
			return s;
		endfunction

		function elem_t fmul(elem_t a, elem_t b);
			elem_t r;
			r = '0;
			for (int i = gfld_pkg::M - 1; i >= 0; i--) begin
				r = times_t(r);
				if (b[i])
					r ^= a;
			end
			return r;
		endfunction

		function elem_t fsq(elem_t a);
			return fmul(a, a);
		endfunction

		function point_t dbl(elem_t x, elem_t y, elem_t z, elem_t a, elem_t b);
			elem_t x2, y2, z2, bz4, z3, x3, inner;
			point_t p;
			x2 = fsq(x);
			y2 = fsq(y);
			z2 = fsq(z);
			bz4 = fmul(b, fsq(z2));
			z3 = fmul(x2, z2);
			x3 = fsq(x2) ^ bz4;
			inner = fmul(a, z3) ^ y2 ^ bz4;
			p.x = x3;
			p.y = fmul(bz4, z3) ^ fmul(x3, inner);
			p.z = z3;
			return p;
		endfunction

		function point_t mixed(elem_t x1, elem_t y1, elem_t z1, elem_t x2, elem_t y2,
			elem_t a, elem_t b);
			elem_t z1s, az2, ta, tb, tc, td, z3, te, x3, tf, tg;
			point_t p;
			z1s = fsq(z1);
			az2 = fmul(a, z1s);
			ta = fmul(y2, z1s) ^ y1;
			tb = fmul(x2, z1) ^ x1;
			if (tb == '0)
				return dbl(x2, y2, elem_t'(1), a, b);
			tc = fmul(z1, tb);
			td = fmul(fsq(tb), tc ^ az2);
			z3 = fsq(tc);
			te = fmul(ta, tc);
			x3 = fsq(ta) ^ td ^ te;
			tf = fmul(x2, z3) ^ x3;
			tg = fmul(x2 ^ y2, fsq(z3));
			p.x = x3;
			p.y = fmul(te ^ z3, tf) ^ tg;
			p.z = z3;
			return p;
		endfunction

		function point_t padd(elem_t x1, elem_t y1, elem_t z1, elem_t x2, elem_t y2,
			elem_t z2);
			elem_t a1, a2, c, b1, b2, d, e1, e2, g;
			point_t p;
			a1 = fmul(x1, z2);
			a2 = fmul(x2, z1);
			c = a1 ^ a2;
			b1 = fsq(a1);
			b2 = fsq(a2);
			d = b1 ^ b2;
			e1 = fmul(y1, fsq(z2));
			e2 = fmul(y2, fsq(z1));
			g = fmul(c, e1 ^ e2);
			p.z = fmul(fmul(z1, z2), d);
			p.x = fmul(a1, e2 ^ b2) ^ fmul(a2, e1 ^ b1);
			p.y = fmul(fmul(a1, g) ^ fmul(e1, d), d) ^ fmul(g ^ p.z, p.x);
			return p;
		endfunction

		function void note_item(op_t op, elem_t fx, elem_t fy, elem_t fz,
			elem_t sx, elem_t sy, elem_t sz);
			elem_t one, a, b;
			point_t p;
			one = elem_t'(1);
			a = fmul(one, ca);
			b = fmul(one, cb);
			fx = fmul(one, fx);
			fy = fmul(one, fy);
			fz = fmul(one, fz);
			sx = fmul(one, sx);
			sy = fmul(one, sy);
			sz = fmul(one, sz);
			p = '{default: '0};
			case (op)
				gfld_pkg::OP_DBL: p = dbl(fx, fy, fz, a, b);
				gfld_pkg::OP_MIX: p = mixed(fx, fy, fz, sx, sy, a, b);
				gfld_pkg::OP_ADD: p = padd(fx, fy, fz, sx, sy, sz);
				default: p = '{default: '0};
			endcase
			pending.push_back(p);
		endfunction

		task check_result(elem_t rx, elem_t ry, elem_t rz);
			point_t e;
			checked++;
			if (pending.size() == 0) begin
				report_mismatch("result with nothing expected", '0, rx);
				return;
			end
			e = pending.pop_front();
			if (rx !== e.x)
				report_mismatch("result_x", e.x, rx);
			if (ry !== e.y)
				report_mismatch("result_y", e.y, ry);
			if (rz !== e.z)
				report_mismatch("result_z", e.z, rz);
		endtask

		task report_mismatch(string what, elem_t want, elem_t got);
			mismatches++;
			$display("mismatch %s: expected %h, got %h", what, want, got);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] opcode = '0;
	elem_t first_x = '0, first_y = '0, first_z = '0;
	elem_t second_x = '0, second_y = '0, second_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	elem_t result_x, result_y, result_z;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	elem_t cfg_data = '0;

	point_scoreboard board;
	bit hold_go = 1'b0;
	bit hold_done = 1'b0;
	int hold_count = 0;
	int stall_mode;
	int items_sent;

	gf2m_lopez_dahab_point_ops dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic elem_t rand_elem();
		elem_t v;
		int k;
		v = elem_t'({$urandom, $urandom});
		k = $urandom_range(0, 9);
		if (k == 0)
			v = '0;
		else if (k == 1)
			v = '1;
		else if (k == 2)
			v = elem_t'($urandom_range(0, 7));
		else if (k == 3)
			v = elem_t'(1) << $urandom_range(0, gfld_pkg::M - 1);
		return v;
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result(result_x, result_y, result_z);
		if (hold_go && !hold_done) begin
			out_stall <= 1'b1;
			if (hold_count == 149)
				hold_done <= 1'b1;
			hold_count <= hold_count + 1;
		end else begin
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				default: out_stall <= ($urandom_range(0, 1) == 0);
			endcase
		end
	end

	task automatic write_reg(logic [1:0] idx, elem_t val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			gfld_pkg::CFG_TAIL: board.tail = val;
			gfld_pkg::CFG_A: board.ca = val;
			default: board.cb = val;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic send_point(op_t op, elem_t fx, elem_t fy, elem_t fz,
		elem_t sx, elem_t sy, elem_t sz);
		in_valid <= 1'b1;
		opcode <= op;
		first_x <= fx;
		first_y <= fy;
		first_z <= fz;
		second_x <= sx;
		second_y <= sy;
		second_z <= sz;
		do
			@(posedge clk);
		while (in_stall);
		board.note_item(op, fx, fy, fz, sx, sy, sz);
		items_sent++;
	endtask

	task automatic send_random(bit mixed_hit);
		op_t op;
		elem_t fx, fz, sx;
		op = op_t'($urandom_range(0, 3));
		fz = rand_elem();
		sx = rand_elem();
		fx = rand_elem();
		if (mixed_hit) begin
			op = gfld_pkg::OP_MIX;
			fx = board.fmul(board.fmul(elem_t'(1), sx), board.fmul(elem_t'(1), fz));
		end
		send_point(op, fx, rand_elem(), fz, sx, rand_elem(), rand_elem());
	endtask

	task automatic idle_gap();
		in_valid <= 1'b0;
		repeat ($urandom_range(1, 6))
			@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (50)
			@(posedge clk);
	endtask

	task automatic random_phase(int count);
		int burst;
		while (count > 0) begin
			burst = $urandom_range(1, 20);
			while (burst > 0 && count > 0) begin
				send_random($urandom_range(0, 7) == 0);
				burst--;
				count--;
			end
			if ($urandom_range(0, 2) != 0)
				idle_gap();
		end
	endtask

	initial begin
		#50ms;
		$display("gf2m_lopez_dahab_point_ops_test failed");
		$finish;
	end

	initial begin
		elem_t tails[4];
		board = new();
		board.tail = gfld_pkg::TAIL_RST;
		board.ca = gfld_pkg::A_RST;
		board.cb = gfld_pkg::B_RST;
		stall_mode = 0;
		items_sent = 0;
		tails[0] = gfld_pkg::TAIL_RST;
		tails[1] = elem_t'(1);
		tails[2] = '1;
		tails[3] = elem_t'(64'h0000_0000_0000_001b);
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_point(gfld_pkg::OP_DBL, '0, '0, '0, '0, '0, '0);
		send_point(gfld_pkg::OP_DBL, '1, '1, '1, '0, '0, '0);
		send_point(gfld_pkg::OP_DBL, elem_t'(2), elem_t'(3), elem_t'(1), '1, '1, '1);
		send_point(gfld_pkg::OP_MIX, '1, '1, '1, '1, '1, '0);
		send_point(gfld_pkg::OP_MIX, elem_t'(5), elem_t'(7), elem_t'(1), elem_t'(5),
			elem_t'(9), '0);
		send_point(gfld_pkg::OP_MIX, '0, elem_t'(4), '0, elem_t'(6), elem_t'(8), '1);
		send_point(gfld_pkg::OP_MIX, elem_t'(3), elem_t'(4), elem_t'(1), elem_t'(6),
			elem_t'(8), '0);
		send_point(gfld_pkg::OP_ADD, '1, '1, '1, '1, '1, '1);
		send_point(gfld_pkg::OP_ADD, elem_t'(1), elem_t'(2), elem_t'(3), elem_t'(4),
			elem_t'(5), '0);
		send_point(gfld_pkg::OP_ADD, '0, '0, '0, '0, '0, '0);
		send_point(gfld_pkg::OP_NONE, '1, '1, '1, '1, '1, '1);
		send_point(gfld_pkg::OP_NONE, '0, '0, '0, '0, '0, '0);
		drain();

		for (int phase = 0; phase < 5; phase++) begin
			write_reg(gfld_pkg::CFG_TAIL, tails[phase % 4]);
			write_reg(gfld_pkg::CFG_A, (phase == 1) ? '0 : (phase == 2) ? '1 : rand_elem());
			write_reg(gfld_pkg::CFG_B, (phase == 1) ? '1 : (phase == 2) ? '0 : rand_elem());
			stall_mode = phase % 3;
			if (phase == 2) begin
				hold_go = 1'b1;
				random_phase(60);
			end
			random_phase(100);
			drain();
		end

		$display("covered %0d items in five register settings, %0d results checked",
			items_sent, board.checked);
		$display("including full-pipeline back-pressure and the mixed-add doubling case");
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("gf2m_lopez_dahab_point_ops_test passed");
		else
			$display("gf2m_lopez_dahab_point_ops_test failed");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/gfld_pkg.sv
sv/gf2m_lopez_dahab_point_ops.sv
tb/gf2m_lopez_dahab_point_ops_test.sv
